// ===== src/itoa_pkg.sv =====
package itoa_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CharWidth  = 8;
  localparam int unsigned PlaceWidth = 4;
  localparam int unsigned StepWidth  = 2;
  localparam int unsigned TrialWidth = ValueWidth + 4;

  localparam logic [PlaceWidth-1:0] TopPlace = 4'd9;
  localparam logic [StepWidth-1:0]  TopStep  = 2'd3;

  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharMinus = 8'h2D;

  function automatic logic [ValueWidth-1:0] pow10(input logic [PlaceWidth-1:0] place);
    logic [ValueWidth-1:0] p;
    case (place)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      4'd9:    p = 32'd1000000000;
      default: p = 32'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== src/signed_int_to_decimal_ascii.sv =====
// Converts a signed 32-bit request into decimal ASCII, most significant character first.
// A request is taken when start is high and busy is low; busy then stays high until the last digit is sent.
// Each of ten decimal places takes four compare-subtract steps on one shared 36-bit subtractor.
// A minus sign appears in the cycle after the request; each digit follows the last step of its place.
// Results are strobed by out_valid for one cycle each; the receiver cannot stall them.
// Synchronous active-low reset clears the sequencer and the strobe; nothing is kept between requests.
module signed_int_to_decimal_ascii
  import itoa_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [ValueWidth-1:0] in_value,
  output logic                        busy,
  output logic                        out_valid,
  output logic [CharWidth-1:0]        out_ascii_char,
  output logic                        out_last_char
);

  typedef enum logic {
    ST_IDLE,
    ST_DIGIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [ValueWidth-1:0] mag_r, mag_nxt;
  logic [PlaceWidth-1:0] place_r, place_nxt;
  logic [StepWidth-1:0]  step_r, step_nxt;
  logic [3:0]            digit_r, digit_nxt;
  logic                  started_r, started_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CharWidth-1:0]  out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [TrialWidth-2:0] shifted;
  logic [TrialWidth-1:0] diff;
  logic                  take;
  logic [3:0]            digit_full;

  always_comb begin
    shifted    = {3'b000, pow10(place_r)} << step_r;
    diff       = {4'b0000, mag_r} - {1'b0, shifted};
    take       = ~diff[TrialWidth-1];
    digit_full = digit_r | (4'(take) << step_r);
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    place_nxt     = place_r;
    step_nxt      = step_r;
    digit_nxt     = digit_r;
    started_nxt   = started_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt   = ST_DIGIT;
          mag_nxt     = in_value[ValueWidth-1] ? (32'd0 - in_value) : in_value;
          place_nxt   = TopPlace;
          step_nxt    = TopStep;
          digit_nxt   = 4'd0;
          started_nxt = 1'b0;
          if (in_value[ValueWidth-1]) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = CharMinus;
            out_last_nxt  = 1'b0;
          end
        end
      end
      ST_DIGIT: begin
        if (take) begin
          mag_nxt = diff[ValueWidth-1:0];
        end
        if (step_r == '0) begin
          if (started_r || (digit_full != 4'd0) || (place_r == '0)) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = CharZero + {4'd0, digit_full};
            out_last_nxt  = (place_r == '0);
            started_nxt   = 1'b1;
          end
          digit_nxt = 4'd0;
          step_nxt  = TopStep;
          if (place_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            place_nxt = place_r - 1'b1;
          end
        end else begin
          digit_nxt = digit_full;
          step_nxt  = step_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
    end
    mag_r      <= mag_nxt;
    place_r    <= place_nxt;
    step_r     <= step_nxt;
    digit_r    <= digit_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_ascii_char = out_char_r;
  assign out_last_char  = out_last_r;

endmodule

// ===== tb/signed_int_to_decimal_ascii_tb.sv =====
module signed_int_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import itoa_pkg::*;

  localparam int unsigned DecimalRadix = 10;
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned MaxGap       = 10;

  typedef struct packed {
    logic [CharWidth-1:0] ascii_char;
    logic                 last_char;
  } text_char_t;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic signed [ValueWidth-1:0] in_value;
  logic                         busy;
  logic                         out_valid;
  logic [CharWidth-1:0]         out_ascii_char;
  logic                         out_last_char;

  text_char_t pending_chars[$];
  int         error_count;
  int         numbers_sent;
  int         negatives_sent;
  int         chars_checked;

  signed_int_to_decimal_ascii u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_value       (in_value),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_ascii_char (out_ascii_char),
    .out_last_char  (out_last_char)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Builds the expected characters of one number and appends them to the pending store.
  function automatic void predict_decimal_text(input logic signed [ValueWidth-1:0] value);
    logic [ValueWidth-1:0] magnitude;
    logic [3:0]            digits[11];
    int                    ndig;
    text_char_t            c;
    magnitude = value;
    if (value[ValueWidth-1]) begin
      magnitude = 32'd0 - magnitude;
      c.ascii_char = CharMinus;
      c.last_char = 1'b0;
      pending_chars.push_back(c);
    end
    ndig = 0;
    do begin
      digits[ndig] = 4'(magnitude % DecimalRadix);
      ndig++;
      magnitude = magnitude / DecimalRadix;
    end while (magnitude != 0);
    for (int i = ndig - 1; i >= 0; i--) begin
      c.ascii_char = CharZero + {4'd0, digits[i]};
      c.last_char = (i == 0);
      pending_chars.push_back(c);
    end
  endfunction

  task automatic send_number(input logic signed [ValueWidth-1:0] value, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (busy);
    predict_decimal_text(value);
    numbers_sent++;
    if (value < 0) negatives_sent++;
  endtask

  task automatic wait_until_drained();
    start <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic signed [ValueWidth-1:0] random_with_digits(input int ndig,
                                                                       input bit negative);
    longint lo;
    longint hi;
    longint magnitude;
    lo = 1;
    for (int i = 1; i < ndig; i++) lo = lo * DecimalRadix;
    hi = lo * DecimalRadix - 1;
    if (ndig == 1) lo = 0;
    if (negative && hi > 64'sd2147483648) hi = 64'sd2147483648;
    if (!negative && hi > 64'sd2147483647) hi = 64'sd2147483647;
    magnitude = longint'($urandom_range(32'(hi - lo), 0)) + lo;
    return 32'(negative ? -magnitude : magnitude);
  endfunction

  task automatic test_directed_extremes();
    logic signed [ValueWidth-1:0] values[$];
    values = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd100,
               32'sd2147483647, 32'h80000000, -32'sd2147483647, 32'sd1000000000,
               -32'sd1000000000, 32'sd999999999, -32'sd999999999, 32'sd1000000007,
               -32'sd2000000001, 32'sd12345, 32'h55555555, 32'hAAAAAAAA, 32'h7FFFFFFE,
               32'sd1234567890};
    foreach (values[i]) send_number(values[i], $urandom_range(MaxGap, 0));
  endtask

  task automatic test_random_full_range(input int count);
    repeat (count) send_number($urandom, $urandom_range(MaxGap, 0));
  endtask

  task automatic test_random_digit_counts(input int count);
    repeat (count) begin
      send_number(random_with_digits($urandom_range(10, 1), 1'($urandom_range(1, 0))),
                  $urandom_range(MaxGap, 0));
    end
  endtask

  // Digits drawn mostly as zero give internal and trailing zero places.
  task automatic test_sparse_digits(input int count);
    longint magnitude;
    repeat (count) begin
      magnitude = longint'($urandom_range(9, 1));
      for (int i = $urandom_range(9, 1); i > 0; i--) begin
        magnitude = magnitude * DecimalRadix;
        if ($urandom_range(3, 0) == 0) magnitude = magnitude + $urandom_range(9, 1);
      end
      if (magnitude > 64'sd2147483647) magnitude = magnitude % 64'sd2000000000;
      send_number(32'($urandom_range(1, 0) ? -magnitude : magnitude),
                  $urandom_range(MaxGap, 0));
    end
  endtask

  task automatic test_back_to_back(input int count);
    repeat (count) send_number($urandom, 0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character: ascii_char 0x%02h last_char %0b",
               out_ascii_char, out_last_char);
        error_count++;
      end else begin
        text_char_t exp_char;
        exp_char = pending_chars.pop_front();
        chars_checked++;
        if (out_ascii_char !== exp_char.ascii_char) begin
          $error("ascii_char mismatch: expected 0x%02h actual 0x%02h",
                 exp_char.ascii_char, out_ascii_char);
          error_count++;
        end
        if (out_last_char !== exp_char.last_char) begin
          $error("last_char mismatch: expected %0b actual %0b",
                 exp_char.last_char, out_last_char);
          error_count++;
        end
      end
    end
  end

  initial begin
    error_count = 0;
    numbers_sent = 0;
    negatives_sent = 0;
    chars_checked = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_value <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    wait_until_drained();
    test_random_full_range(50);
    wait_until_drained();
    test_random_digit_counts(50);
    test_sparse_digits(25);
    wait_until_drained();
    test_back_to_back(25);
    wait_until_drained();

    if (pending_chars.size() != 0) begin
      $error("%0d expected characters never arrived", pending_chars.size());
      error_count++;
    end
    $display("Converted %0d numbers (%0d negative) and checked %0d characters.",
             numbers_sent, negatives_sent, chars_checked);
    $display("Covered zero, both extremes, every digit count and back-to-back requests.");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout: the run did not finish in time.");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
